// ----- rtl/mca_pkg.sv -----
package mca_pkg;

   // Default number of scanned channels.
   localparam int CHANNELS_DEFAULT = 16;

   // Fixed field widths.
   localparam int ACC_W    = 16;
   localparam int SAMPLE_W = 10;
   localparam int CHAN_W   = 4;
   localparam int VALUE_W  = 10;
   localparam int SHIFT_W  = 3;
   localparam int PASS_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Full scale of a reading and the special scale maxima.
   localparam logic [VALUE_W-1:0] FULL_SCALE   = 10'd1023;
   localparam logic [VALUE_W-1:0] EIGHTH_SCALE = 10'd127;
   localparam int                 EIGHTH_SHIFT = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSES_NEEDED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CUTOFF    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_CUTOFF   = 2'd3;

   // Register reset values.
   localparam logic [SHIFT_W-1:0] SAMPLE_SHIFT_RESET  = 3'd2;
   localparam logic [PASS_W-1:0]  PASSES_NEEDED_RESET = 8'd4;
   localparam logic [VALUE_W-1:0] LOW_CUTOFF_RESET    = 10'd8;
   localparam logic [VALUE_W-1:0] HIGH_CUTOFF_RESET   = 10'd1016;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_READ    = 2'd1,
      REQ_RESTART = 2'd2
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCALE
   } state_type;

   // Write-back command to the accumulator memory.
   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } mem_op_type;

endpackage

// ----- rtl/mca_acc_mem.sv -----
module mca_acc_mem #(
   parameter int CHANNELS = mca_pkg::CHANNELS_DEFAULT,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [mca_pkg::ACC_W-1:0]   rd_data,
   input  mca_pkg::mem_op_type         wr_op,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [mca_pkg::ACC_W-1:0]   wr_data
);
   import mca_pkg::*;

   logic [ACC_W-1:0]    acc_mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [ACC_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;

   // Accumulator words; an entry whose valid bit is clear reads as zero.
   always_ff @(posedge clock) begin
      if (wr_op.wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= acc_mem[rd_addr];
      end
   end

   // Valid bits give the all-zero reset and the clear on a read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_op.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (wr_op.clr_en) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/mca_average.sv -----
module mca_average (
   input  logic                          clock,
   input  logic                          load,
   input  logic [mca_pkg::ACC_W-1:0]     raw_sum,
   input  logic [mca_pkg::SHIFT_W-1:0]   sample_shift,
   input  logic [mca_pkg::VALUE_W-1:0]   low_cutoff,
   input  logic [mca_pkg::VALUE_W-1:0]   high_cutoff,
   input  logic [mca_pkg::VALUE_W-1:0]   scale_max,
   output logic [mca_pkg::VALUE_W-1:0]   value
);
   import mca_pkg::*;

   localparam int PROD_W = 2 * VALUE_W;

   logic signed [ACC_W-1:0]   avg;
   logic signed [ACC_W:0]     low_s;
   logic signed [ACC_W:0]     high_s;
   logic signed [ACC_W:0]     avg_s;
   logic [VALUE_W-1:0]        clamp_in;
   logic [PROD_W-1:0]         prod_in;
   logic [PROD_W-1:0]         prod_ff;
   logic [VALUE_W-1:0]        clamp_ff;
   logic                      full_ff;
   logic                      eighth_ff;
   logic [VALUE_W-1:0]        quot0;
   logic [VALUE_W:0]          rem0;
   logic [VALUE_W-1:0]        quot;

   // First stage: arithmetic shift into an average, clamp, then multiply.
   always_comb begin
      avg    = $signed(raw_sum) >>> sample_shift;
      avg_s  = {avg[ACC_W-1], avg};
      low_s  = $signed({{(ACC_W + 1 - VALUE_W){1'b0}}, low_cutoff});
      high_s = $signed({{(ACC_W + 1 - VALUE_W){1'b0}}, high_cutoff});
      priority if (avg_s < low_s) begin
         clamp_in = '0;
      end else if (avg_s > high_s) begin
         clamp_in = FULL_SCALE;
      end else begin
         clamp_in = avg[VALUE_W-1:0];
      end
      prod_in = clamp_in * scale_max;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff   <= prod_in;
         clamp_ff  <= clamp_in;
         full_ff   <= (scale_max == FULL_SCALE);
         eighth_ff <= (scale_max == EIGHTH_SCALE);
      end
   end

   // Second stage: divide the product by 1023, or take the clamp for a full scale maximum and shifted right by three
   // for an eighth. The quotient estimate from dividing by 1024 is low by at most one, which one compare corrects.
   always_comb begin
      quot0 = prod_ff[PROD_W-1:VALUE_W];
      rem0  = {1'b0, prod_ff[VALUE_W-1:0]} + {1'b0, quot0};
      if (rem0 >= {1'b0, FULL_SCALE}) begin
         quot = quot0 + VALUE_W'(1);
      end else begin
         quot = quot0;
      end
      priority if (full_ff) begin
         value = clamp_ff;
      end else if (eighth_ff) begin
         value = clamp_ff >> EIGHTH_SHIFT;
      end else begin
         value = quot;
      end
   end

endmodule

// ----- rtl/multichannel_adc_accumulator.sv -----
// Round-robin ADC oversampling accumulator.
// Request channel (req_*): one item per request. A sample item adds its
// conversion to the accumulator of the channel being scanned and moves the
// scan on; a read item returns the shifted, clamped and scaled average of the
// named channel and clears that accumulator; a restart item returns the scan
// to channel 0 and clears the pass count. Every item gives one response item.
// Response channel (rsp_*): value (zero except for reads), data_ready and the
// channel the multiplexer should select next.
// Timing: an item is taken in the idle cycle, the accumulator memory is read
// and written back in the next (ST_EXEC), and the divide by 1023 for scaling
// fills ST_SCALE; a new item is not taken until the response is loaded. The
// response is registered when the block leaves ST_SCALE. The registered memory
// read and the registered multiplier set these states.
// While a response is stalled the block may take one further item, which
// then waits in its final cycle until the response register is free.
// Reset (synchronous) clears every accumulator at once, the scan index and
// the pass count, and loads the configuration defaults. The request channel
// stalls while reset is high.
module multichannel_adc_accumulator #(
   parameter int CHANNELS = mca_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [mca_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [mca_pkg::CHAN_W-1:0]       req_channel,
   input  logic [mca_pkg::VALUE_W-1:0]      req_scale_max,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mca_pkg::VALUE_W-1:0]      rsp_value,
   output logic                             rsp_data_ready,
   output logic [mca_pkg::CHAN_W-1:0]       rsp_next_channel,
   input  logic                             csr_wr_en,
   input  logic [mca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mca_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mca_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

   state_type            state_ff, state_in;
   logic                 accept;
   logic                 out_free;
   logic                 exec_en;
   logic                 rsp_load;

   logic [SHIFT_W-1:0]   sample_shift_ff;
   logic [PASS_W-1:0]    passes_needed_ff;
   logic [VALUE_W-1:0]   low_cutoff_ff;
   logic [VALUE_W-1:0]   high_cutoff_ff;

   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [PASS_W-1:0]    pass_ff, pass_in;

   logic [1:0]           code_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [VALUE_W-1:0]   scale_max_ff;
   logic [IDX_W-1:0]     addr_ff;
   logic                 in_range_ff;
   logic                 is_read_ff;

   logic [IDX_W+CHAN_W-1:0] chan_wide;
   logic [IDX_W-1:0]     chan_addr;
   logic                 chan_in_range;
   logic [IDX_W-1:0]     rd_addr;
   logic [ACC_W-1:0]     rd_data;
   logic [ACC_W-1:0]     raw_sum;
   mem_op_type           wr_op;
   logic [ACC_W-1:0]     wr_data;
   logic [VALUE_W-1:0]   avg_value;
   logic [IDX_W+CHAN_W-1:0] scan_wide;

   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_ready_ff;
   logic [CHAN_W-1:0]    rsp_chan_ff;

   // Handshake terms.
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Channel number of a read mapped onto the memory address.
   assign chan_wide     = {{IDX_W{1'b0}}, req_channel};
   assign chan_addr     = chan_wide[IDX_W-1:0];
   assign chan_in_range = (32'(req_channel) < CHANNELS);
   assign rd_addr       = (req_type == REQ_READ) ? chan_addr : scan_ff;

   // Sequencer: idle, memory access and write-back, scaling and response.
   always_comb begin
      state_in = state_ff;
      exec_en  = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            exec_en  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_shift_ff  <= SAMPLE_SHIFT_RESET;
         passes_needed_ff <= PASSES_NEEDED_RESET;
         low_cutoff_ff    <= LOW_CUTOFF_RESET;
         high_cutoff_ff   <= HIGH_CUTOFF_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_SHIFT:  sample_shift_ff  <= csr_wdata[SHIFT_W-1:0];
            CSR_PASSES_NEEDED: passes_needed_ff <= csr_wdata[PASS_W-1:0];
            CSR_LOW_CUTOFF:    low_cutoff_ff    <= csr_wdata[VALUE_W-1:0];
            CSR_HIGH_CUTOFF:   high_cutoff_ff   <= csr_wdata[VALUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item held for the duration of its processing.
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff      <= req_type;
         sample_ff    <= req_sample;
         scale_max_ff <= req_scale_max;
         addr_ff      <= rd_addr;
         in_range_ff  <= (req_type == REQ_READ) ? chan_in_range : 1'b1;
      end
   end

   // Write-back and scan update in the memory access cycle.
   assign raw_sum = in_range_ff ? rd_data : '0;
   assign wr_data = rd_data + {{(ACC_W - SAMPLE_W){1'b0}}, sample_ff};

   always_comb begin
      wr_op   = '0;
      scan_in = scan_ff;
      pass_in = pass_ff;
      if (exec_en) begin
         unique case (code_ff)
            REQ_SAMPLE: begin
               wr_op.wr_en = 1'b1;
               if (scan_ff == LAST_IDX) begin
                  scan_in = '0;
                  pass_in = pass_ff + PASS_W'(1);
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
            REQ_READ: begin
               wr_op.clr_en = in_range_ff;
            end
            REQ_RESTART: begin
               scan_in = '0;
               pass_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         pass_ff <= '0;
      end else begin
         scan_ff <= scan_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         is_read_ff <= (code_ff == REQ_READ);
      end
   end

   mca_acc_mem #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_acc_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_op   (wr_op),
      .wr_addr (addr_ff),
      .wr_data (wr_data)
   );

   mca_average u_average (
      .clock        (clock),
      .load         (exec_en),
      .raw_sum      (raw_sum),
      .sample_shift (sample_shift_ff),
      .low_cutoff   (low_cutoff_ff),
      .high_cutoff  (high_cutoff_ff),
      .scale_max    (scale_max_ff),
      .value        (avg_value)
   );

   // Response register.
   assign scan_wide = {{CHAN_W{1'b0}}, scan_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= is_read_ff ? avg_value : '0;
         rsp_ready_ff <= (pass_ff == passes_needed_ff);
         rsp_chan_ff  <= scan_wide[CHAN_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_data_ready   = rsp_ready_ff;
   assign rsp_next_channel = rsp_chan_ff;

endmodule

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mca_pkg::*;

   localparam int NUM_CHANNELS = CHANNELS_DEFAULT;
   localparam int RANDOM_ITEMS = 1200;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SATURATE_SAMPLES = 600;

   // The request code that the block leaves unused.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               data_ready;
      logic [CHAN_W-1:0]  next_channel;
   } response_type;

   // Mirror of the accumulator bank, scan position and registers. It works out
   // the response to each accepted item and checks responses in order.
   class accumulator_mirror;
      bit [ACC_W-1:0]    sums[NUM_CHANNELS];
      int                scan_index;
      bit [PASS_W-1:0]   pass_count;
      bit [SHIFT_W-1:0]  avg_shift;
      bit [PASS_W-1:0]   passes_needed;
      bit [VALUE_W-1:0]  low_cutoff;
      bit [VALUE_W-1:0]  high_cutoff;
      response_type      expected_responses[$];
      int                failures;

      function new();
         foreach (sums[i]) sums[i] = '0;
         scan_index    = 0;
         pass_count    = '0;
         avg_shift     = SAMPLE_SHIFT_RESET;
         passes_needed = PASSES_NEEDED_RESET;
         low_cutoff    = LOW_CUTOFF_RESET;
         high_cutoff   = HIGH_CUTOFF_RESET;
         failures      = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_SHIFT:  avg_shift     = data[SHIFT_W-1:0];
            CSR_PASSES_NEEDED: passes_needed = data[PASS_W-1:0];
            CSR_LOW_CUTOFF:    low_cutoff    = data[VALUE_W-1:0];
            CSR_HIGH_CUTOFF:   high_cutoff   = data[VALUE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] code, logic [SAMPLE_W-1:0] sample,
                                 logic [CHAN_W-1:0] channel, logic [VALUE_W-1:0] scale_max);
         logic signed [ACC_W-1:0] raw;
         int                      average;
         int                      clamped;
         response_type            resp;
         resp.value = '0;
         case (code)
            REQ_SAMPLE: begin
               sums[scan_index] = sums[scan_index] + ACC_W'(sample);
               if (scan_index == NUM_CHANNELS - 1) begin
                  scan_index = 0;
                  pass_count = pass_count + 1'b1;
               end else begin
                  scan_index = scan_index + 1;
               end
            end
            REQ_READ: begin
               raw = '0;
               if (channel < NUM_CHANNELS) begin
                  raw = sums[channel];
                  sums[channel] = '0;
               end
               // The sum is signed, so the average keeps its sign.
               average = raw >>> avg_shift;
               if (average < int'(low_cutoff))
                  clamped = 0;
               else if (average > int'(high_cutoff))
                  clamped = int'(FULL_SCALE);
               else
                  clamped = average;
               if (scale_max == FULL_SCALE)
                  resp.value = VALUE_W'(clamped);
               else if (scale_max == EIGHTH_SCALE)
                  resp.value = VALUE_W'(clamped >> EIGHTH_SHIFT);
               else
                  resp.value = VALUE_W'(clamped * int'(scale_max) / int'(FULL_SCALE));
            end
            REQ_RESTART: begin
               scan_index = 0;
               pass_count = '0;
            end
            default: ;
         endcase
         resp.data_ready   = (pass_count == passes_needed);
         resp.next_channel = CHAN_W'(scan_index);
         expected_responses.push_back(resp);
      endfunction

      function void check_response(logic [VALUE_W-1:0] value, logic data_ready,
                                   logic [CHAN_W-1:0] next_channel);
         response_type want;
         if (expected_responses.size() == 0) begin
            $error("response item arrived with none expected");
            failures++;
            return;
         end
         want = expected_responses.pop_front();
         if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            failures++;
         end
         if (data_ready !== want.data_ready) begin
            $error("data_ready: expected %0d, got %0d", want.data_ready, data_ready);
            failures++;
         end
         if (next_channel !== want.next_channel) begin
            $error("next_channel: expected %0d, got %0d", want.next_channel, next_channel);
            failures++;
         end
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = REQ_SAMPLE;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic [CHAN_W-1:0]     req_channel = '0;
   logic [VALUE_W-1:0]    req_scale_max = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic                  rsp_data_ready;
   logic [CHAN_W-1:0]     rsp_next_channel;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   accumulator_mirror mirror = new();
   int idle_cycles = 0;

   multichannel_adc_accumulator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample       (req_sample),
      .req_channel      (req_channel),
      .req_scale_max    (req_scale_max),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_data_ready   (rsp_data_ready),
      .rsp_next_channel (rsp_next_channel),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap before a request item: mostly none or short, now and then long.
   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Field values weighted towards their extremes.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return VALUE_W'(1);
         2: return EIGHTH_SCALE;
         3: return FULL_SCALE;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Present one request item and hold it until the block takes it.
   task automatic send_request(logic [1:0] code, logic [SAMPLE_W-1:0] sample,
                               logic [CHAN_W-1:0] channel, logic [VALUE_W-1:0] scale_max,
                               int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= code;
      req_sample    <= sample;
      req_channel   <= channel;
      req_scale_max <= scale_max;
      do @(posedge clock); while (req_stall);
      mirror.note_request(code, sample, channel, scale_max);
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      mirror.set_register(idx, data);
   endtask

   task automatic configure(int shift, int passes, int low, int high);
      write_register(CSR_SAMPLE_SHIFT,  CSR_DATA_W'(shift));
      write_register(CSR_PASSES_NEEDED, CSR_DATA_W'(passes));
      write_register(CSR_LOW_CUTOFF,    CSR_DATA_W'(low));
      write_register(CSR_HIGH_CUTOFF,   CSR_DATA_W'(high));
      csr_wr_en <= 1'b0;
   endtask

   // Response stall: runs of free cycles and stalls, now and then long ones.
   initial begin : stall_driver
      int roll;
      @(negedge reset);
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            repeat ($urandom_range(1, 4)) @(posedge clock);
         else if (roll < 90)
            repeat ($urandom_range(5, 20)) @(posedge clock);
         else
            repeat ($urandom_range(50, 150)) @(posedge clock);
         rsp_stall <= 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 80)
            repeat ($urandom_range(1, 3)) @(posedge clock);
         else if (roll < 95)
            repeat ($urandom_range(4, 10)) @(posedge clock);
         else
            repeat ($urandom_range(20, 60)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted response item is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_response(rsp_value, rsp_data_ready, rsp_next_channel);
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no progress for %0d cycles", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int         sent;
      int         phase;
      int         length;
      int         roll;
      bit         steady;
      logic [1:0] code;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: one sample on channel 0, read back as an average.
      send_request(REQ_SAMPLE, '1, 4'd0, FULL_SCALE, 0);
      send_request(REQ_READ, '0, 4'd0, FULL_SCALE, 0);
      drain();

      // One full pass with no shift and open cutoffs, so data ready rises after it.
      configure(0, 1, 0, 1023);
      for (int i = 0; i < NUM_CHANNELS; i++)
         send_request(REQ_SAMPLE, (i % 2 == 0) ? SAMPLE_W'(1023) : SAMPLE_W'(i),
                      CHAN_W'(i), '0, 0);
      // Every scaling case, a read of the top channel and a read of a cleared channel.
      send_request(REQ_READ, '0, 4'd0, FULL_SCALE, 0);
      send_request(REQ_READ, '0, 4'd2, EIGHTH_SCALE, 0);
      send_request(REQ_READ, '0, 4'd4, '0, 0);
      send_request(REQ_READ, '0, 4'd6, VALUE_W'(1), 0);
      send_request(REQ_READ, '0, 4'd15, VALUE_W'(500), 0);
      send_request(REQ_READ, '0, 4'd0, FULL_SCALE, 0);
      // Restart, the unused code, then a sample and read after the restart.
      send_request(REQ_RESTART, '1, 4'd15, '1, 0);
      send_request(REQ_UNUSED, '1, 4'd9, '1, 0);
      send_request(REQ_SAMPLE, SAMPLE_W'(300), 4'd0, '0, 0);
      send_request(REQ_READ, '0, 4'd1, FULL_SCALE, 0);
      drain();

      // Random phases, each under its own register setting.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            configure(6, 2, 16, 1000);
         end else if (phase == 1) begin
            configure(7, 255, 1023, 0);
         end else begin
            case ($urandom_range(0, 4))
               0: roll = 0;
               1: roll = 6;
               2: roll = 7;
               default: roll = $urandom_range(0, 6);
            endcase
            configure(roll,
                      ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(1, 4),
                      ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 64),
                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(700, 1023));
         end

         if (phase == 1) begin
            // Long run of large samples so the sums pass the sign bit, then read all.
            for (int i = 0; i < SATURATE_SAMPLES; i++)
               send_request(REQ_SAMPLE,
                            ($urandom_range(0, 3) == 0) ? SAMPLE_W'(1023)
                                                        : SAMPLE_W'($urandom_range(900, 1023)),
                            CHAN_W'($urandom), pick_scale(), pick_gap(steady));
            for (int i = 0; i < NUM_CHANNELS; i++)
               send_request(REQ_READ, pick_sample(), CHAN_W'(i), pick_scale(),
                            pick_gap(steady));
            sent += SATURATE_SAMPLES + NUM_CHANNELS;
         end else begin
            length = $urandom_range(60, 160);
            for (int i = 0; i < length; i++) begin
               roll = $urandom_range(0, 99);
               if (roll < 62)
                  code = REQ_SAMPLE;
               else if (roll < 88)
                  code = REQ_READ;
               else if (roll < 95)
                  code = REQ_RESTART;
               else
                  code = REQ_UNUSED;
               send_request(code, pick_sample(), CHAN_W'($urandom), pick_scale(),
                            pick_gap(steady));
            end
            sent += length;
         end
         drain();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (mirror.pending() != 0) begin
         $error("%0d expected response items never arrived", mirror.pending());
         mirror.failures++;
      end
      if (mirror.failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mca_pkg.sv
rtl/mca_acc_mem.sv
rtl/mca_average.sv
rtl/multichannel_adc_accumulator.sv
dv/testbench.sv
